@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int FIELD_WIDTH = 16;
	localparam int COUNT_OUT_WIDTH = 4;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value, compares it with the value
// being inserted and loads the new value or a left or right neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int W = 16
) (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic [W-1:0]        new_val,
	input  logic                prev_keep,
	input  logic [W-1:0]        prev_val,
	input  logic [W-1:0]        next_val,
	output logic                keep,
	output logic [W-1:0]        val
);
	import spq_pkg::*;

	logic [W-1:0] val_q;

	assign keep = occupied && (val_q >= new_val);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && !keep) begin
			val_q <= prev_keep ? new_val : prev_val;
		end else if (ctrl.remove) begin
			val_q <= next_val;
		end
	end

endmodule

@@ design/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue kept as a descending chain of cells.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     cmd, value
//  result    done (strobe)    status, removed_value, head_value, item_count,
//                             is_empty, is_full
//
//  One transaction per cycle: busy stays low, every cell compares in parallel.
//  The result strobes done in the cycle after the command is taken.
//  Reset clears the count; cell contents are not reset.
//  The receiver cannot stall; results are shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int SLOTS       = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic                                     cmd,
	input  logic [spq_pkg::FIELD_WIDTH-1:0]          value,
	output logic                                     done,
	output logic [1:0]                               status,
	output logic [spq_pkg::FIELD_WIDTH-1:0]          removed_value,
	output logic [spq_pkg::FIELD_WIDTH-1:0]          head_value,
	output logic [spq_pkg::COUNT_OUT_WIDTH-1:0]      item_count,
	output logic                                     is_empty,
	output logic                                     is_full
);
	import spq_pkg::*;

	localparam int CAP = SLOTS - 1;
	localparam int SW  = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
	localparam int CW  = $clog2(SLOTS);
	localparam logic [CW-1:0] CAP_C = CW'(CAP);

	logic          accept;
	logic [SW-1:0] new_val;
	logic [CW-1:0] count_q;
	logic          done_q;
	status_t       status_q;
	logic [SW-1:0] removed_q;
	cell_ctrl_t    ctrl;
	logic          full_now;
	logic          empty_now;

	logic [SW-1:0] val_w  [CAP];
	logic          keep_w [CAP];

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign new_val   = value[SW-1:0];
	assign full_now  = (count_q == CAP_C);
	assign empty_now = (count_q == '0);

	always_comb begin
		ctrl.insert = accept && (cmd == CMD_INSERT) && !full_now;
		ctrl.remove = accept && (cmd == CMD_REMOVE) && !empty_now;
	end

	for (genvar k = 0; k < CAP; k++) begin : g_cell
		logic          prev_keep;
		logic [SW-1:0] prev_val;
		logic [SW-1:0] next_val;

		if (k == 0) begin : g_first
			assign prev_keep = 1'b1;
			assign prev_val  = new_val;
		end else begin : g_mid
			assign prev_keep = keep_w[k-1];
			assign prev_val  = val_w[k-1];
		end

		if (k == CAP - 1) begin : g_last
			assign next_val = val_w[k];
		end else begin : g_inner
			assign next_val = val_w[k+1];
		end

		spq_cell #(
			.W(SW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (CW'(k) < count_q),
			.new_val  (new_val),
			.prev_keep(prev_keep),
			.prev_val (prev_val),
			.next_val (next_val),
			.keep     (keep_w[k]),
			.val      (val_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.insert) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= ctrl.remove ? val_w[0] : '0;
			if (cmd == CMD_INSERT) begin
				status_q <= full_now ? STATUS_FULL : STATUS_DONE;
			end else begin
				status_q <= empty_now ? STATUS_EMPTY : STATUS_DONE;
			end
		end
	end

	// cells already hold the post-transaction state during the done cycle
	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = FIELD_WIDTH'(removed_q);
	assign head_value    = empty_now ? '0 : FIELD_WIDTH'(val_w[0]);
	assign item_count    = COUNT_OUT_WIDTH'(count_q);
	assign is_empty      = empty_now;
	assign is_full       = full_now;

endmodule

@@ design/spq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic [1:0]                          status,
	input logic [spq_pkg::FIELD_WIDTH-1:0]     removed_value,
	input logic [spq_pkg::FIELD_WIDTH-1:0]     head_value,
	input logic                                is_empty,
	input logic                                is_full
);
	import spq_pkg::*;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transaction taken without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a transaction");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_EMPTY) |->
		(is_empty && removed_value == '0 && head_value == '0))
		else $error("empty removal reported wrong fields");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> (is_full && removed_value == '0))
		else $error("rejected insert while not full");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.removed_value(removed_value),
	.head_value   (head_value),
	.is_empty     (is_empty),
	.is_full      (is_full)
);
